FILE: hw/rtl/kvp_pkg.sv
`timescale 1ns / 1ps
package kvp_pkg;

	// Key buffer depth and derived widths
	localparam int KEY_MAX = 16;
	localparam int CNT_W   = $clog2(KEY_MAX + 1);
	localparam int IDX_W   = $clog2(KEY_MAX);
	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 3;

	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;

	// Parser mode
	typedef enum logic [1:0] {
		MODE_KEY = 2'd0,
		MODE_VAL = 2'd1,
		MODE_NL  = 2'd2,
		MODE_MSG = 2'd3
	} mode_t;

	// Result kind codes
	typedef enum logic [KIND_W-1:0] {
		K_KEY    = 3'd0,
		K_VAL    = 3'd1,
		K_MSG    = 3'd2,
		K_KEYEND = 3'd3,
		K_VALEND = 3'd4,
		K_OBJEND = 3'd5
	} kind_t;

	// Byte source of an emitted result
	typedef enum logic [1:0] {
		SRC_ZERO = 2'd0,
		SRC_BYTE = 2'd1,
		SRC_NL   = 2'd2,
		SRC_KEY  = 2'd3
	} src_t;

	// Emission plan of one request, in emission order
	typedef struct packed {
		logic  pre;
		logic  single;
		kind_t single_kind;
		src_t  single_src;
		logic  flush;
		kind_t flush_kind;
		logic  tail;
		kind_t tail_kind;
		src_t  tail_src;
		logic  endve;
		logic  obj;
	} plan_t;

	// Controller to datapath
	typedef struct packed {
		logic  ready;
		logic  accept;
		logic  emit;
		kind_t kind;
		src_t  src;
		logic  last;
		logic  flush_step;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic  in_valid;
		plan_t plan;
		logic  flush_last;
		logic  out_free;
	} sts_t;

endpackage

FILE: hw/rtl/kvp_in_if.sv
`timescale 1ns / 1ps
interface kvp_in_if;
	import kvp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              in_last;

	modport source(output valid, output in_byte, output in_last, input ready);
	modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

FILE: hw/rtl/kvp_out_if.sv
`timescale 1ns / 1ps
interface kvp_out_if;
	import kvp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic [KIND_W-1:0] kind;
	logic              key_overflow;
	logic              last_of_run;

	modport source(output valid, output out_byte, output kind, output key_overflow,
		output last_of_run, input ready);
	modport sink(input valid, input out_byte, input kind, input key_overflow,
		input last_of_run, output ready);
endinterface

FILE: hw/rtl/kvp_ram.sv
`timescale 1ns / 1ps
module kvp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port, registered read with write-first forwarding
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: hw/rtl/kvp_datapath.sv
`timescale 1ns / 1ps
module kvp_datapath (
	input  logic           clk,
	input  logic           arst_n,
	kvp_in_if.sink         data,
	kvp_out_if.source      result,
	input  kvp_pkg::cmd_t  cmd,
	output kvp_pkg::sts_t  sts
);
	import kvp_pkg::*;

	mode_t             mode_q, mode_mid, mode_nxt;
	logic [CNT_W-1:0]  count_q, count_mid, count_nxt;
	logic              ovf_q, ovf_set;
	logic [BYTE_W-1:0] byte_q;
	logic [CNT_W-1:0]  flush_n_q, flush_n_d;
	logic [CNT_W-1:0]  idx_q, idx_inc, raddr_full;
	logic              wr_en, body_fl, is_sp, is_nl, pre_ve, eff_key;
	plan_t             plan;
	logic [BYTE_W-1:0] key_rdata;
	logic [BYTE_W-1:0] emit_byte;

	logic              ov_q;
	logic [BYTE_W-1:0] out_byte_q;
	kind_t             out_kind_q;
	logic              out_ovf_q, out_last_q;

	// Decode of the incoming byte against the current mode
	always_comb begin
		is_sp     = (data.in_byte == CH_SPACE);
		is_nl     = (data.in_byte == CH_NL);
		pre_ve    = (mode_q == MODE_NL) && !is_sp;
		eff_key   = (mode_q == MODE_KEY) || pre_ve;
		plan      = '0;
		plan.pre  = pre_ve;
		plan.single_kind = K_VAL;
		plan.single_src  = SRC_BYTE;
		plan.flush_kind  = K_MSG;
		plan.tail_kind   = K_MSG;
		plan.tail_src    = SRC_ZERO;
		mode_mid  = mode_q;
		count_mid = count_q;
		wr_en     = 1'b0;
		ovf_set   = 1'b0;
		body_fl   = 1'b0;
		if (eff_key) begin
			mode_mid = MODE_KEY;
			if (is_sp) begin
				body_fl         = 1'b1;
				plan.flush      = (count_q != '0);
				plan.flush_kind = K_KEY;
				plan.tail       = 1'b1;
				plan.tail_kind  = K_KEYEND;
				plan.tail_src   = SRC_ZERO;
				mode_mid        = MODE_VAL;
				count_mid       = '0;
			end else if (is_nl) begin
				// line without a space, or a blank line, opens the message
				body_fl         = 1'b1;
				plan.flush      = (count_q != '0);
				plan.flush_kind = K_MSG;
				plan.tail       = (count_q != '0);
				plan.tail_kind  = K_MSG;
				plan.tail_src   = SRC_NL;
				mode_mid        = MODE_MSG;
				count_mid       = '0;
			end else if (count_q < CNT_W'(KEY_MAX)) begin
				wr_en     = 1'b1;
				count_mid = count_q + CNT_W'(1);
			end else begin
				ovf_set = 1'b1;
			end
		end else if (mode_q == MODE_VAL) begin
			if (is_nl) begin
				mode_mid = MODE_NL;
			end else begin
				plan.single      = 1'b1;
				plan.single_kind = K_VAL;
				plan.single_src  = SRC_BYTE;
			end
		end else if (mode_q == MODE_NL) begin
			// continuation: keep the newline, drop the space
			plan.single      = 1'b1;
			plan.single_kind = K_VAL;
			plan.single_src  = SRC_NL;
			mode_mid         = MODE_VAL;
		end else begin
			plan.single      = 1'b1;
			plan.single_kind = K_MSG;
			plan.single_src  = SRC_BYTE;
		end

		flush_n_d = body_fl ? count_q : count_mid;

		// End of object
		if (data.in_last) begin
			plan.obj = 1'b1;
			if (mode_mid == MODE_KEY) begin
				plan.flush      = (count_mid != '0);
				plan.flush_kind = K_MSG;
			end else if ((mode_mid == MODE_VAL) || (mode_mid == MODE_NL)) begin
				plan.endve = 1'b1;
			end
			mode_nxt  = MODE_KEY;
			count_nxt = '0;
		end else begin
			mode_nxt  = mode_mid;
			count_nxt = count_mid;
		end
	end

	// Parser state and flush index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_KEY;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			flush_n_q <= '0;
			idx_q     <= '0;
		end else if (cmd.accept) begin
			mode_q    <= mode_nxt;
			count_q   <= count_nxt;
			ovf_q     <= ovf_q | ovf_set;
			flush_n_q <= flush_n_d;
			idx_q     <= '0;
		end else if (cmd.flush_step) begin
			idx_q <= idx_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= data.in_byte;
		end
	end

	// Key buffer; read address runs one ahead of the emitted entry
	assign idx_inc = idx_q + CNT_W'(1);

	always_comb begin
		if (cmd.accept) begin
			raddr_full = '0;
		end else if (cmd.flush_step && !sts.flush_last) begin
			raddr_full = idx_inc;
		end else begin
			raddr_full = idx_q;
		end
	end

	kvp_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(KEY_MAX)
	) u_key_ram (
		.clk  (clk),
		.we   (cmd.accept && wr_en),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(data.in_byte),
		.raddr(raddr_full[IDX_W-1:0]),
		.rdata(key_rdata)
	);

	// Result byte select
	always_comb begin
		unique case (cmd.src)
			SRC_ZERO: emit_byte = '0;
			SRC_BYTE: emit_byte = byte_q;
			SRC_NL:   emit_byte = CH_NL;
			SRC_KEY:  emit_byte = key_rdata;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= emit_byte;
			out_kind_q <= cmd.kind;
			out_ovf_q  <= ovf_q;
			out_last_q <= cmd.last;
		end
	end

	assign result.valid        = ov_q;
	assign result.out_byte     = out_byte_q;
	assign result.kind         = out_kind_q;
	assign result.key_overflow = out_ovf_q;
	assign result.last_of_run  = out_last_q;
	assign data.ready          = cmd.ready;

	// Status
	assign sts.in_valid   = data.valid;
	assign sts.plan       = plan;
	assign sts.flush_last = (idx_inc == flush_n_q);
	assign sts.out_free   = !ov_q || result.ready;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(KEY_MAX))
		else $error("key count beyond buffer depth");
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("overflow flag cleared");
	a_flush_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush_step |-> (idx_q < flush_n_q))
		else $error("flush index past buffered count");
`endif
endmodule

FILE: hw/rtl/kvp_ctrl.sv
`timescale 1ns / 1ps
module kvp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  kvp_pkg::sts_t sts,
	output kvp_pkg::cmd_t cmd
);
	import kvp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_SINGLE,
		ST_FLUSH,
		ST_TAIL,
		ST_ENDVE,
		ST_OBJ
	} state_t;

	state_t state_q, state_nxt;
	plan_t  plan_q, plan_rem;

	// First phase still pending in a plan
	function automatic state_t first_phase(input plan_t p);
		state_t s;
		if (p.pre) begin
			s = ST_PRE;
		end else if (p.single) begin
			s = ST_SINGLE;
		end else if (p.flush) begin
			s = ST_FLUSH;
		end else if (p.tail) begin
			s = ST_TAIL;
		end else if (p.endve) begin
			s = ST_ENDVE;
		end else if (p.obj) begin
			s = ST_OBJ;
		end else begin
			s = ST_IDLE;
		end
		return s;
	endfunction

	// Phase decode and commands
	always_comb begin
		plan_rem       = plan_q;
		cmd.ready      = (state_q == ST_IDLE);
		cmd.accept     = (state_q == ST_IDLE) && sts.in_valid;
		cmd.emit       = (state_q != ST_IDLE) && sts.out_free;
		cmd.kind       = K_VALEND;
		cmd.src        = SRC_ZERO;
		cmd.flush_step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.emit = 1'b0;
			end
			ST_PRE: begin
				plan_rem.pre = 1'b0;
			end
			ST_SINGLE: begin
				plan_rem.single = 1'b0;
				cmd.kind        = plan_q.single_kind;
				cmd.src         = plan_q.single_src;
			end
			ST_FLUSH: begin
				plan_rem.flush = !sts.flush_last;
				cmd.kind       = plan_q.flush_kind;
				cmd.src        = SRC_KEY;
				cmd.flush_step = sts.out_free;
			end
			ST_TAIL: begin
				plan_rem.tail = 1'b0;
				cmd.kind      = plan_q.tail_kind;
				cmd.src       = plan_q.tail_src;
			end
			ST_ENDVE: begin
				plan_rem.endve = 1'b0;
			end
			ST_OBJ: begin
				plan_rem.obj = 1'b0;
				cmd.kind     = K_OBJEND;
			end
		endcase
		state_nxt = first_phase(plan_rem);
		cmd.last  = (state_nxt == ST_IDLE);
	end

	// State and plan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			plan_q  <= '0;
		end else if (cmd.accept) begin
			state_q <= first_phase(sts.plan);
			plan_q  <= sts.plan;
		end else if (cmd.emit) begin
			state_q <= state_nxt;
			plan_q  <= plan_rem;
		end
	end

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result emitted into a full output register");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == ST_IDLE))
		else $error("sequencer busy after final result");
	a_flush_plan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> plan_q.flush)
		else $error("flush phase without pending flush");
`endif
endmodule

FILE: hw/rtl/key_value_message_parser.sv
`timescale 1ns / 1ps
// Acceptance loads the sequencer state; the first result of a request is then registered in the output register.
// The sequencer takes no new request until every result of the current one is
// emitted; key flushes emit one buffered byte per cycle from the key RAM read
// port while the output register is free, and output stalls hold the sequencer.
// Reset: arst_n clears mode to key, key count, overflow flag and output valid.
module key_value_message_parser (
	input  logic      clk,
	input  logic      arst_n,
	kvp_in_if.sink    data,
	kvp_out_if.source result
);
	import kvp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	kvp_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	kvp_datapath u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.data  (data),
		.result(result),
		.cmd   (cmd),
		.sts   (sts)
	);
endmodule

FILE: tb/tb_key_value_message_parser.sv
`timescale 1ns / 1ps
module tb_key_value_message_parser;
	import kvp_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_ITEMS  = 115;
	localparam int MAX_SHOWN   = 10;

	// How a stimulus row is checked
	typedef enum logic [1:0] {
		CHK_MODEL = 2'd0,
		CHK_ONE   = 2'd1,
		CHK_NONE  = 2'd2
	} row_chk_t;

	// One emitted token as seen on the result channel
	typedef struct packed {
		logic [BYTE_W-1:0] obyte;
		kind_t             kind;
		logic              ovf;
		logic              lastr;
	} token_t;

	// One byte request plus how its tokens are checked
	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              lst;
		row_chk_t          chk;
		token_t            typed;
	} req_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	kvp_in_if  data_ch();
	kvp_out_if res_ch();

	key_value_message_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.data   (data_ch),
		.result (res_ch)
	);

	always #6 clk = ~clk;

	// Shadow parser state
	mode_t             sh_mode;
	logic [BYTE_W-1:0] sh_key [KEY_MAX];
	int                sh_len;
	logic              sh_ovf;
	token_t            step_tokens[$];

	token_t awaited_tokens[$];
	req_t   reqs[$];
	bit     hold_go;
	int     hold_cycles;
	int     errors;
	int     n_tokens;
	int     n_objects;
	int     n_overflow_objs;

	// Token emission into the current step
	function automatic void put_token(logic [BYTE_W-1:0] b, kind_t k);
		token_t t;
		t.obyte = b;
		t.kind  = k;
		t.ovf   = 1'b0;
		t.lastr = 1'b0;
		step_tokens.insert(step_tokens.size(), t);
	endfunction

	function automatic void flush_key(kind_t k);
		for (int i = 0; i < sh_len; i++)
			put_token(sh_key[i], k);
		sh_len = 0;
	endfunction

	// A byte seen while collecting a key
	function automatic void take_key_char(logic [BYTE_W-1:0] c);
		if (c == CH_SPACE) begin
			flush_key(K_KEY);
			put_token('0, K_KEYEND);
			sh_mode = MODE_VAL;
		end else if (c == CH_NL) begin
			if (sh_len != 0) begin
				flush_key(K_MSG);
				put_token(c, K_MSG);
			end
			sh_mode = MODE_MSG;
		end else if (sh_len < KEY_MAX) begin
			sh_key[sh_len] = c;
			sh_len++;
		end else begin
			sh_ovf = 1'b1;
		end
	endfunction

	// Tokens produced by one accepted byte request
	function automatic void parse_step(logic [BYTE_W-1:0] c, logic lst);
		step_tokens.delete();
		case (sh_mode)
			MODE_KEY: take_key_char(c);
			MODE_VAL: begin
				if (c == CH_NL)
					sh_mode = MODE_NL;
				else
					put_token(c, K_VAL);
			end
			MODE_NL: begin
				if (c == CH_SPACE) begin
					put_token(CH_NL, K_VAL);
					sh_mode = MODE_VAL;
				end else begin
					put_token('0, K_VALEND);
					sh_mode = MODE_KEY;
					take_key_char(c);
				end
			end
			default: put_token(c, K_MSG);
		endcase
		// object end: leftover key goes out as message, open value is closed
		if (lst) begin
			if (sh_mode == MODE_KEY)
				flush_key(K_MSG);
			else if (sh_mode == MODE_VAL || sh_mode == MODE_NL)
				put_token('0, K_VALEND);
			put_token('0, K_OBJEND);
			sh_mode = MODE_KEY;
			sh_len  = 0;
		end
		foreach (step_tokens[i]) begin
			step_tokens[i].ovf   = sh_ovf;
			step_tokens[i].lastr = (i == step_tokens.size() - 1);
		end
	endfunction

	// Directed table row; rep repeats the same byte
	function automatic void row(logic [BYTE_W-1:0] b, logic lst, row_chk_t chk = CHK_MODEL,
		kind_t k = K_KEY, logic [BYTE_W-1:0] ob = '0, logic ovf = 1'b0, int rep = 1);
		req_t r;
		r.b           = b;
		r.lst         = lst;
		r.chk         = chk;
		r.typed.obyte = ob;
		r.typed.kind  = k;
		r.typed.ovf   = ovf;
		r.typed.lastr = 1'b1;
		repeat (rep)
			reqs.insert(reqs.size(), r);
	endfunction

	function automatic logic [BYTE_W-1:0] key_char();
		logic [BYTE_W-1:0] b;
		if ($urandom_range(0, 7) == 0) begin
			do
				b = BYTE_W'($urandom_range(0, 255));
			while (b == CH_SPACE || b == CH_NL);
		end else begin
			b = BYTE_W'($urandom_range(33, 126));
		end
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] value_char();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(0, 255));
		while (b == CH_NL);
		return b;
	endfunction

	// One random object: mostly well-formed headers, some noise and truncation
	function automatic void gen_object();
		logic [BYTE_W-1:0] obj[$];
		int                shape;
		int                klen;
		int                cut;
		req_t              r;
		shape = $urandom_range(0, 9);
		if (shape == 0) begin
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(0, 9))
					0:       obj.insert(obj.size(), CH_SPACE);
					1:       obj.insert(obj.size(), CH_NL);
					default: obj.insert(obj.size(), BYTE_W'($urandom_range(0, 255)));
				endcase
			end
		end else if (shape == 1) begin
			// line with no space, then message
			repeat ($urandom_range(1, 6))
				obj.insert(obj.size(), key_char());
			obj.insert(obj.size(), CH_NL);
			repeat ($urandom_range(0, 6))
				obj.insert(obj.size(), BYTE_W'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 15))
					0:       klen = 0;
					1, 2:    klen = $urandom_range(14, 20);
					default: klen = $urandom_range(1, 8);
				endcase
				repeat (klen)
					obj.insert(obj.size(), key_char());
				obj.insert(obj.size(), CH_SPACE);
				repeat ($urandom_range(0, 8))
					obj.insert(obj.size(), value_char());
				if ($urandom_range(0, 3) == 0) begin
					obj.insert(obj.size(), CH_NL);
					obj.insert(obj.size(), CH_SPACE);
					repeat ($urandom_range(0, 6))
						obj.insert(obj.size(), value_char());
				end
				obj.insert(obj.size(), CH_NL);
			end
			if ($urandom_range(0, 1) == 0) begin
				obj.insert(obj.size(), CH_NL);
				repeat ($urandom_range(0, 8))
					obj.insert(obj.size(), BYTE_W'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 4) == 0 && obj.size() > 1) begin
			cut = $urandom_range(1, obj.size() - 1);
			obj = obj[0:cut-1];
		end
		foreach (obj[i]) begin
			r.b     = obj[i];
			r.lst   = (i == obj.size() - 1);
			r.chk   = CHK_MODEL;
			r.typed = '0;
			reqs.insert(reqs.size(), r);
		end
	endfunction

	// Receiver: segments of random stall patterns plus one long hold-off
	initial begin
		int seg_left;
		int seg_mode;
		res_ch.ready <= 1'b0;
		seg_left    = 0;
		seg_mode    = 0;
		hold_cycles = 0;
		forever begin
			@(posedge clk);
			if (hold_go && hold_cycles < HOLD_CYCLES) begin
				res_ch.ready <= 1'b0;
				hold_cycles++;
			end else begin
				if (seg_left == 0) begin
					seg_mode = $urandom_range(0, 3);
					seg_left = $urandom_range(4, 40);
				end
				seg_left--;
				case (seg_mode)
					0:       res_ch.ready <= 1'b1;
					1:       res_ch.ready <= $urandom_range(0, 1);
					2:       res_ch.ready <= ($urandom_range(0, 5) == 0);
					default: res_ch.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	task automatic report(string why, token_t want, token_t got);
		errors++;
		if (errors <= MAX_SHOWN)
			$display("%0t %s: exp %h/%0d/%b/%b, got %h/%0d/%b/%b (byte/kind/ovf/last)",
				$realtime, why, want.obyte, want.kind, want.ovf, want.lastr,
				got.obyte, got.kind, got.ovf, got.lastr);
	endtask

	// Result checker
	always @(posedge clk) begin
		token_t got;
		token_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.obyte = res_ch.out_byte;
			got.kind  = kind_t'(res_ch.kind);
			got.ovf   = res_ch.key_overflow;
			got.lastr = res_ch.last_of_run;
			n_tokens++;
			if (awaited_tokens.size() == 0) begin
				report("unexpected token", '0, got);
			end else begin
				want = awaited_tokens.pop_front();
				if (got.obyte !== want.obyte || got.kind !== want.kind ||
					got.ovf !== want.ovf || got.lastr !== want.lastr)
					report("token mismatch", want, got);
			end
		end
	end

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d tokens outstanding", cycles,
					awaited_tokens.size());
				$display("tb_key_value_message_parser: done, errors");
				$finish;
			end
		end
	end

	// Sender
	initial begin
		int   n_dir;
		int   burst;
		req_t r;
		data_ch.valid   <= 1'b0;
		data_ch.in_byte <= '0;
		data_ch.in_last <= 1'b0;
		hold_go = 1'b0;
		errors  = 0;
		sh_mode = MODE_KEY;
		sh_len  = 0;
		sh_ovf  = 1'b0;

		// empty key, extreme bytes, continuation, value end, continuation at end
		row(CH_SPACE, 1'b0, CHK_ONE, K_KEYEND, 8'h00, 1'b0);
		row(8'hFF, 1'b0, CHK_ONE, K_VAL, 8'hFF, 1'b0);
		row(8'h00, 1'b0, CHK_ONE, K_VAL, 8'h00, 1'b0);
		row(CH_NL, 1'b0, CHK_NONE);
		row(CH_SPACE, 1'b0, CHK_ONE, K_VAL, CH_NL, 1'b0);
		row(CH_NL, 1'b0, CHK_NONE);
		row("t", 1'b0, CHK_ONE, K_VALEND, 8'h00, 1'b0);
		row("k", 1'b0, CHK_NONE);
		row(CH_SPACE, 1'b0);
		row(CH_NL, 1'b0, CHK_NONE);
		row(CH_SPACE, 1'b1);
		// key overflow, then newline as last byte of a value
		row("k", 1'b0, CHK_MODEL, K_KEY, 8'h00, 1'b0, KEY_MAX + 1);
		row(CH_SPACE, 1'b0);
		row("v", 1'b0, CHK_ONE, K_VAL, "v", 1'b1);
		row(CH_NL, 1'b1);
		// blank line starts the message
		row(CH_NL, 1'b0, CHK_NONE);
		row(CH_SPACE, 1'b0, CHK_ONE, K_MSG, CH_SPACE, 1'b1);
		row(8'hFF, 1'b1);
		// line without a space
		row("a", 1'b0, CHK_NONE);
		row("b", 1'b0, CHK_NONE);
		row(CH_NL, 1'b0);
		row(CH_NL, 1'b0, CHK_ONE, K_MSG, CH_NL, 1'b1);
		row(8'h00, 1'b1);
		// lone blank line as a whole object, and a key cut short by object end
		row(CH_NL, 1'b1, CHK_ONE, K_OBJEND, 8'h00, 1'b1);
		row("q", 1'b1);
		n_dir = reqs.size();
		while (reqs.size() - n_dir < RAND_ITEMS)
			gen_object();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst = $urandom_range(1, 16);
		for (int i = 0; i < reqs.size(); i++) begin
			// drain everything before the random part, then start the long hold-off
			if (i == n_dir) begin
				data_ch.valid <= 1'b0;
				while (awaited_tokens.size() != 0)
					@(posedge clk);
				repeat (4) @(posedge clk);
				hold_go = 1'b1;
			end
			r = reqs[i];
			data_ch.valid   <= 1'b1;
			data_ch.in_byte <= r.b;
			data_ch.in_last <= r.lst;
			do
				@(posedge clk);
			while (data_ch.ready !== 1'b1);
			parse_step(r.b, r.lst);
			if (r.lst) begin
				n_objects++;
				if (sh_ovf)
					n_overflow_objs++;
			end
			case (r.chk)
				CHK_ONE:  awaited_tokens.insert(awaited_tokens.size(), r.typed);
				CHK_NONE: ;
				default: begin
					foreach (step_tokens[j])
						awaited_tokens.insert(awaited_tokens.size(), step_tokens[j]);
				end
			endcase
			// burst / gap shaping
			burst--;
			if (burst == 0) begin
				data_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) :
					$urandom_range(1, 8);
			end
		end
		data_ch.valid <= 1'b0;

		while (awaited_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("run: %0d byte requests in %0d objects (%0d after a key overflow), %0d tokens",
			reqs.size(), n_objects, n_overflow_objs, n_tokens);
		$display("run: receiver held off %0d cycles, %0d mismatches", hold_cycles, errors);
		if (errors == 0)
			$display("tb_key_value_message_parser: done, clean");
		else
			$display("tb_key_value_message_parser: done, errors");
		$finish;
	end

endmodule
